### rtl/ptslm_pkg.sv
package ptslm_pkg;

  // Ring geometry
  localparam int SampleDepth = 16;
  localparam int IdxW = (SampleDepth > 1) ? $clog2(SampleDepth) : 1;
  localparam int CntW = $clog2(SampleDepth + 1);

  // Field widths
  localparam int StampW = 32;
  localparam int CfgW = 10;
  localparam int UsW = 21;
  localparam int TotalW = 14;
  localparam int ByteW = 7;
  localparam int ReqW = 3;

  // Limits and reset values
  localparam logic [UsW-1:0] UsMax = 21'h1FFFFF;
  localparam logic [TotalW-1:0] TotalMax = 14'h3FFF;
  localparam logic [CfgW-1:0] CfgReset = 10'd72;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_MARK   = 3'd0,
    REQ_TAKE   = 3'd1,
    REQ_BEGIN  = 3'd2,
    REQ_END    = 3'd3,
    REQ_SENT   = 3'd4,
    REQ_REPORT = 3'd5
  } req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

### rtl/ptslm_div.sv
// Restoring divider, one quotient bit per cycle.
module ptslm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ptslm_pkg::StampW-1:0]      dividend,
  input  logic [ptslm_pkg::CfgW-1:0]        divisor,
  output logic                              done,
  output logic [ptslm_pkg::StampW-1:0]      quotient
);

  localparam int StepW = $clog2(ptslm_pkg::StampW);

  logic                            running;
  logic [StepW-1:0]                step_cnt;
  logic [ptslm_pkg::StampW-1:0]    dvd;
  logic [ptslm_pkg::CfgW-1:0]      rem;
  logic [ptslm_pkg::CfgW:0]        trial;
  logic                            fits;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    trial = {rem, dvd[ptslm_pkg::StampW-1]};
    fits  = trial >= {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step_cnt <= StepW'(ptslm_pkg::StampW - 1);
      end else if (running) begin
        step_cnt <= step_cnt - StepW'(1);
        if (step_cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out on top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[ptslm_pkg::StampW-2:0], fits};
      rem <= fits ? ptslm_pkg::CfgW'(trial - {1'b0, divisor})
                  : ptslm_pkg::CfgW'(trial);
    end
  end

  assign quotient = dvd;

endmodule

### rtl/press_to_send_latency_monitor_unit.sv
// Mark, take, begin, end and ignored events complete without raising busy.
// A closing sent event holds busy through the 32-step serial divide, one bit per cycle.
// A report holds busy while it sends 5 + 3 * stored samples bytes, one byte per cycle.
// Report bytes start the cycle after the request is accepted; the receiver cannot stall.
// Synchronous active-high rst clears all control state; us_divisor resets to 72.
module press_to_send_latency_monitor_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ptslm_pkg::ReqW-1:0]      req_type,
  input  logic [ptslm_pkg::StampW-1:0]    stamp,
  input  logic                            from_interrupt,
  input  logic                            clear_after,
  input  logic                            cfg_write,
  input  logic [ptslm_pkg::CfgW-1:0]      cfg_data,
  output logic                            result_valid,
  output logic [ptslm_pkg::ByteW-1:0]     report_byte,
  output logic                            last_byte
);

  localparam int IdxW = ptslm_pkg::IdxW;
  localparam int CntW = ptslm_pkg::CntW;
  localparam int UsW  = ptslm_pkg::UsW;

  ptslm_pkg::state_t state, state_next;

  logic [ptslm_pkg::CfgW-1:0]     us_divisor;
  logic [ptslm_pkg::StampW-1:0]   pending_time;
  logic                           pending_valid;
  logic [ptslm_pkg::StampW-1:0]   pass_time;
  logic                           pass_armed;
  logic [ptslm_pkg::StampW-1:0]   open_time;
  logic                           open_flag;
  logic [IdxW-1:0]                write_index;
  logic [CntW-1:0]                stored_count;
  logic [ptslm_pkg::TotalW-1:0]   timed_total;
  logic [UsW-1:0]                 worst_us;

  // Sample ring
  logic [UsW-1:0]                 ring [ptslm_pkg::SampleDepth];
  logic [UsW-1:0]                 ring_rdata;
  logic [IdxW-1:0]                rd_ptr;

  // Report serializer
  logic [UsW-1:0]                 rpt_shift;
  logic [1:0]                     byte_cnt;
  logic                           emit_total;
  logic [CntW-1:0]                smp_left;
  logic                           clear_req;

  logic                           accept;
  logic                           div_start;
  logic                           div_done;
  logic [ptslm_pkg::StampW-1:0]   quotient;
  logic [UsW-1:0]                 us_sat;
  logic [CntW-1:0]                wi_ext;
  logic [IdxW-1:0]                first_idx;
  logic                           word_end;

  assign busy      = (state != ptslm_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign div_start = accept && (req_type == ptslm_pkg::REQ_SENT) && open_flag
                     && !from_interrupt;

  ptslm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (stamp - open_time),
    .divisor  (us_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Saturate the quotient to the sample width
  assign us_sat = (|quotient[ptslm_pkg::StampW-1:UsW]) ? ptslm_pkg::UsMax
                                                        : quotient[UsW-1:0];

  // Oldest stored sample
  always_comb begin
    wi_ext = CntW'(write_index);
    if (wi_ext >= stored_count) begin
      first_idx = IdxW'(wi_ext - stored_count);
    end else begin
      first_idx = IdxW'(wi_ext + CntW'(ptslm_pkg::SampleDepth) - stored_count);
    end
  end

  assign word_end = (byte_cnt == 2'd0);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptslm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and outputs
  always_comb begin
    state_next   = state;
    result_valid = 1'b0;
    last_byte    = 1'b0;
    report_byte  = rpt_shift[UsW-1:UsW-ptslm_pkg::ByteW];
    unique case (state)
      ptslm_pkg::S_IDLE: begin
        if (div_start) begin
          state_next = ptslm_pkg::S_DIV;
        end else if (accept && req_type == ptslm_pkg::REQ_REPORT) begin
          state_next = ptslm_pkg::S_EMIT;
        end
      end
      ptslm_pkg::S_DIV: begin
        if (div_done) begin
          state_next = ptslm_pkg::S_IDLE;
        end
      end
      ptslm_pkg::S_EMIT: begin
        result_valid = 1'b1;
        last_byte    = word_end && !emit_total && (smp_left == '0);
        if (last_byte) begin
          state_next = ptslm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptslm_pkg::S_IDLE;
      end
    endcase
  end

  // Ring write and registered read
  always_ff @(posedge clk) begin
    if (state == ptslm_pkg::S_DIV && div_done) begin
      ring[write_index] <= us_sat;
    end
    ring_rdata <= ring[rd_ptr];
  end

  // Event latches, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      us_divisor    <= ptslm_pkg::CfgReset;
      pending_time  <= '0;
      pending_valid <= 1'b0;
      pass_time     <= '0;
      pass_armed    <= 1'b0;
      open_time     <= '0;
      open_flag     <= 1'b0;
      write_index   <= '0;
      stored_count  <= '0;
      timed_total   <= '0;
      worst_us      <= '0;
    end else begin
      if (cfg_write) begin
        us_divisor <= cfg_data;
      end

      if (accept) begin
        unique case (req_type)
          ptslm_pkg::REQ_MARK: begin
            if (!pending_valid) begin
              pending_time  <= stamp;
              pending_valid <= 1'b1;
            end
          end
          ptslm_pkg::REQ_TAKE: begin
            pass_armed    <= pending_valid;
            pass_time     <= pending_time;
            pending_valid <= 1'b0;
          end
          ptslm_pkg::REQ_BEGIN: begin
            open_flag <= pass_armed;
            open_time <= pass_time;
          end
          ptslm_pkg::REQ_END: begin
            open_flag <= 1'b0;
          end
          ptslm_pkg::REQ_SENT: begin
            if (!from_interrupt) begin
              open_flag <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // Sample lands once the divide finishes
      if (state == ptslm_pkg::S_DIV && div_done) begin
        write_index <= (write_index == IdxW'(ptslm_pkg::SampleDepth - 1))
                       ? '0 : write_index + IdxW'(1);
        if (stored_count < CntW'(ptslm_pkg::SampleDepth)) begin
          stored_count <= stored_count + CntW'(1);
        end
        if (timed_total < ptslm_pkg::TotalMax) begin
          timed_total <= timed_total + ptslm_pkg::TotalW'(1);
        end
        if (us_sat > worst_us) begin
          worst_us <= us_sat;
        end
      end

      // Optional clear after the final byte
      if (state == ptslm_pkg::S_EMIT && last_byte && clear_req) begin
        stored_count <= '0;
        timed_total  <= '0;
        worst_us     <= '0;
      end
    end
  end

  // Report serializer: two 7-bit digits for the total, then three per 21-bit word, top digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt   <= '0;
      emit_total <= 1'b0;
      smp_left   <= '0;
      clear_req  <= 1'b0;
      rd_ptr     <= '0;
    end else if (accept && req_type == ptslm_pkg::REQ_REPORT) begin
      rpt_shift  <= {timed_total, ptslm_pkg::ByteW'(0)};
      byte_cnt   <= 2'd1;
      emit_total <= 1'b1;
      smp_left   <= stored_count;
      rd_ptr     <= first_idx;
      clear_req  <= clear_after;
    end else if (state == ptslm_pkg::S_EMIT) begin
      if (!word_end) begin
        rpt_shift <= {rpt_shift[UsW-ptslm_pkg::ByteW-1:0], ptslm_pkg::ByteW'(0)};
        byte_cnt  <= byte_cnt - 2'd1;
      end else if (emit_total) begin
        rpt_shift  <= worst_us;
        byte_cnt   <= 2'd2;
        emit_total <= 1'b0;
      end else if (smp_left != '0) begin
        rpt_shift <= ring_rdata;
        byte_cnt  <= 2'd2;
        smp_left  <= smp_left - CntW'(1);
        rd_ptr    <= (rd_ptr == IdxW'(ptslm_pkg::SampleDepth - 1))
                     ? '0 : rd_ptr + IdxW'(1);
      end
    end
  end

endmodule

### bench/press_to_send_latency_monitor_unit_tb.sv
`timescale 1ns / 100ps

module press_to_send_latency_monitor_unit_tb;

  localparam int ReqW = ptslm_pkg::ReqW;
  localparam int StampW = ptslm_pkg::StampW;
  localparam int TotalW = ptslm_pkg::TotalW;
  localparam int UsW = ptslm_pkg::UsW;
  localparam int ByteW = ptslm_pkg::ByteW;
  localparam int CfgW = ptslm_pkg::CfgW;
  localparam int IdxW = ptslm_pkg::IdxW;
  localparam int CntW = ptslm_pkg::CntW;
  localparam int SampleDepth = ptslm_pkg::SampleDepth;

  // Spare request codes, decoded as no-ops
  localparam logic [ReqW-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE7 = 3'd7;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 60;
  localparam int CfgPause = 40;
  localparam int FillSamples = 20;

  // One request of the stimulus; typed rows carry a fixed report body
  typedef struct packed {
    logic [ReqW-1:0]   req;
    logic [StampW-1:0] stamp;
    logic              fi;
    logic              ca;
    logic              typed;
    logic [TotalW-1:0] tot;
    logic [UsW-1:0]    worst;
  } stim_row_t;

  typedef struct packed {
    logic [ByteW-1:0] rbyte;
    logic             is_last;
  } report_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [ReqW-1:0]   req_type = '0;
  logic [StampW-1:0] stamp = '0;
  logic              from_interrupt = 1'b0;
  logic              clear_after = 1'b0;
  logic              cfg_write = 1'b0;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              result_valid;
  logic [ByteW-1:0]  report_byte;
  logic              last_byte;

  // Fixed expectation travelling with the request
  logic              cur_typed = 1'b0;
  logic [TotalW-1:0] cur_total = '0;
  logic [UsW-1:0]    cur_worst = '0;

  // Predictor state
  logic [CfgW-1:0]   div_cfg = ptslm_pkg::CfgReset;
  logic [StampW-1:0] pend_stamp = '0;
  logic              pend_ok = 1'b0;
  logic [StampW-1:0] pass_stamp = '0;
  logic              pass_ok = 1'b0;
  logic [StampW-1:0] open_stamp = '0;
  logic              open_ok = 1'b0;
  logic [UsW-1:0]    lat_ring [SampleDepth];
  logic [IdxW-1:0]   wr_ptr = '0;
  logic [CntW-1:0]   n_stored = '0;
  logic [TotalW-1:0] press_total = '0;
  logic [UsW-1:0]    worst_lat = '0;

  logic [ByteW-1:0]  report_body [$];
  report_byte_t      bytes_due [$];
  stim_row_t         dir_tab [$];

  int                err_cnt = 0;
  int                stall_cnt = 0;
  int                n_items = 0;

  press_to_send_latency_monitor_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .stamp          (stamp),
    .from_interrupt (from_interrupt),
    .clear_after    (clear_after),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .report_byte    (report_byte),
    .last_byte      (last_byte)
  );

  always #5 clk = ~clk;

  // Update the monitor state for one request; a report fills report_body
  task automatic apply_event(input logic [ReqW-1:0] req, input logic [StampW-1:0] stmp,
                             input logic fi, input logic ca);
    logic [StampW-1:0] elapsed;
    logic [StampW-1:0] quo;
    logic [UsW-1:0]    lat;
    logic [IdxW-1:0]   oldest;
    report_body.delete();
    case (req)
      ptslm_pkg::REQ_MARK: begin
        if (!pend_ok) begin
          pend_stamp = stmp;
          pend_ok = 1'b1;
        end
      end
      ptslm_pkg::REQ_TAKE: begin
        pass_ok = pend_ok;
        pass_stamp = pend_stamp;
        pend_ok = 1'b0;
      end
      ptslm_pkg::REQ_BEGIN: begin
        open_ok = pass_ok;
        open_stamp = pass_stamp;
      end
      ptslm_pkg::REQ_END: begin
        open_ok = 1'b0;
      end
      ptslm_pkg::REQ_SENT: begin
        if (open_ok && !fi) begin
          open_ok = 1'b0;
          if (div_cfg == '0) begin
            lat = ptslm_pkg::UsMax;
          end else begin
            elapsed = stmp - open_stamp;
            quo = elapsed / StampW'(div_cfg);
            lat = (quo > StampW'(ptslm_pkg::UsMax)) ? ptslm_pkg::UsMax : quo[UsW-1:0];
          end
          lat_ring[wr_ptr] = lat;
          wr_ptr = wr_ptr + 1'b1;
          if (n_stored < SampleDepth) n_stored = n_stored + 1'b1;
          if (press_total < ptslm_pkg::TotalMax) press_total = press_total + 1'b1;
          if (lat > worst_lat) worst_lat = lat;
        end
      end
      ptslm_pkg::REQ_REPORT: begin
        report_body.push_back(press_total[13:7]);
        report_body.push_back(press_total[6:0]);
        report_body.push_back(worst_lat[20:14]);
        report_body.push_back(worst_lat[13:7]);
        report_body.push_back(worst_lat[6:0]);
        oldest = wr_ptr - n_stored[IdxW-1:0];
        for (int i = 0; i < n_stored; i++) begin
          lat = lat_ring[oldest + i[IdxW-1:0]];
          report_body.push_back(lat[20:14]);
          report_body.push_back(lat[13:7]);
          report_body.push_back(lat[6:0]);
        end
        if (ca) begin
          n_stored = '0;
          press_total = '0;
          worst_lat = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Track accepted requests and register writes, check report bytes
  always @(posedge clk) begin
    report_byte_t want;
    if (!rst) begin
      if (cfg_write) div_cfg = cfg_data;
      if (start && !busy) begin
        apply_event(req_type, stamp, from_interrupt, clear_after);
        if (cur_typed) begin
          report_body.delete();
          report_body.push_back(cur_total[13:7]);
          report_body.push_back(cur_total[6:0]);
          report_body.push_back(cur_worst[20:14]);
          report_body.push_back(cur_worst[13:7]);
          report_body.push_back(cur_worst[6:0]);
        end
        foreach (report_body[i])
          bytes_due.push_back('{rbyte: report_body[i], is_last: (i == report_body.size() - 1)});
      end
      if (result_valid) begin
        if (bytes_due.size() == 0) begin
          $error("report_byte: no byte expected, actual %0d", report_byte);
          err_cnt++;
        end else begin
          want = bytes_due.pop_front();
          if (report_byte !== want.rbyte) begin
            $error("report_byte: expected %0d, actual %0d", want.rbyte, report_byte);
            err_cnt++;
          end
          if (last_byte !== want.is_last) begin
            $error("last_byte: expected %0d, actual %0d", want.is_last, last_byte);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_write) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic stim_row_t mk_row(input logic [ReqW-1:0] req, input logic [StampW-1:0] s,
                                       input logic fi, input logic ca);
    stim_row_t r;
    r = '0;
    r.req = req;
    r.stamp = s;
    r.fi = fi;
    r.ca = ca;
    return r;
  endfunction

  // Report row whose body is known by inspection (no samples stored)
  function automatic stim_row_t mk_fixed_report(input logic [TotalW-1:0] tot,
                                                input logic [UsW-1:0] worst);
    stim_row_t r;
    r = mk_row(ptslm_pkg::REQ_REPORT, 32'h0, 1'b0, 1'b0);
    r.typed = 1'b1;
    r.tot = tot;
    r.worst = worst;
    return r;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Stamp delta between mark and sent: short, mid-range, near-wrap or fully random
  function automatic logic [StampW-1:0] pick_delta();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(0, 32'h00FF_FFFF);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // Present one request and hold it until accepted
  task automatic drive_req(input stim_row_t r, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= r.req;
    stamp <= r.stamp;
    from_interrupt <= r.fi;
    clear_after <= r.ca;
    cur_typed <= r.typed;
    cur_total <= r.tot;
    cur_worst <= r.worst;
    if (r.req <= ptslm_pkg::REQ_REPORT) n_items++;
    do @(posedge clk); while (busy);
  endtask

  task automatic send(input logic [ReqW-1:0] req, input logic [StampW-1:0] s,
                      input logic fi, input logic ca);
    drive_req(mk_row(req, s, fi, ca), 1'b1);
  endtask

  // Stop requesting until every pending report byte has arrived
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
  endtask

  // Register write with the block idle, divider included
  task automatic write_divisor(input logic [CfgW-1:0] v);
    drain();
    repeat (CfgPause) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random phase: mostly complete press-to-send sequences, some reports and noise
  task automatic run_phase(input logic [CfgW-1:0] v, input int count);
    int target;
    int pick;
    logic [StampW-1:0] m0;
    logic [StampW-1:0] d0;
    write_divisor(v);
    target = n_items + count;
    while (n_items < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        m0 = $urandom;
        d0 = pick_delta();
        send(ptslm_pkg::REQ_MARK, m0, coin(), coin());
        if ($urandom_range(0, 3) == 0) send(ptslm_pkg::REQ_MARK, $urandom, coin(), coin());
        send(ptslm_pkg::REQ_TAKE, $urandom, coin(), coin());
        send(ptslm_pkg::REQ_BEGIN, $urandom, coin(), coin());
        if ($urandom_range(0, 5) == 0) send(ptslm_pkg::REQ_END, $urandom, coin(), coin());
        if ($urandom_range(0, 5) == 0) send(ptslm_pkg::REQ_SENT, m0 + d0, 1'b1, coin());
        send(ptslm_pkg::REQ_SENT, m0 + d0, 1'b0, coin());
      end else if (pick < 8) begin
        send(ptslm_pkg::REQ_REPORT, $urandom, coin(), ($urandom_range(0, 3) == 0));
      end else begin
        send(3'($urandom_range(0, 7)), $urandom, coin(), coin());
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, divisor at its reset value
    dir_tab.push_back(mk_fixed_report('0, '0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'hFFFF_FFFF, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_TAKE, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_BEGIN, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_MARK, 32'h0, 1'b0, 1'b1));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_MARK, 32'hFFFF_FFFF, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_TAKE, 32'h5555_AAAA, 1'b1, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_BEGIN, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'd1234, 1'b1, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'd720, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'd5000, 1'b0, 1'b0));
    // pass latch still valid: reopen and saturate the latency
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_BEGIN, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'hFFFF_FFFF, 1'b0, 1'b1));
    // stamp wraps between mark and sent; end cancels
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_MARK, 32'hFFFF_FFF0, 1'b1, 1'b1));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_TAKE, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_BEGIN, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_END, 32'h0, 1'b1, 1'b1));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'h10, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_BEGIN, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_SENT, 32'h10, 1'b0, 1'b0));
    dir_tab.push_back(mk_row(REQ_SPARE6, 32'hA5A5_5A5A, 1'b1, 1'b1));
    dir_tab.push_back(mk_row(REQ_SPARE7, 32'h5A5A_A5A5, 1'b1, 1'b1));
    dir_tab.push_back(mk_row(ptslm_pkg::REQ_REPORT, 32'h0, 1'b1, 1'b1));
    dir_tab.push_back(mk_fixed_report('0, '0));
    foreach (dir_tab[i]) drive_req(dir_tab[i], 1'b1);

    // Random phases over several divisor settings
    run_phase(10'd1023, 50);
    run_phase(10'd1, 50);
    run_phase(10'd0, 45);
    run_phase(10'($urandom_range(1, 1023)), 50);
    run_phase(ptslm_pkg::CfgReset, 50);
    run_phase(10'($urandom_range(1, 1023)), 45);

    // Back-to-back samples past a full ring, then report the whole ring
    write_divisor(10'd1);
    drive_req(mk_row(ptslm_pkg::REQ_MARK, $urandom, 1'b0, 1'b0), 1'b0);
    drive_req(mk_row(ptslm_pkg::REQ_TAKE, $urandom, 1'b0, 1'b0), 1'b0);
    repeat (FillSamples) begin
      drive_req(mk_row(ptslm_pkg::REQ_BEGIN, $urandom, 1'b0, 1'b0), 1'b0);
      drive_req(mk_row(ptslm_pkg::REQ_SENT, $urandom, 1'b0, 1'b0), 1'b0);
    end
    drive_req(mk_row(ptslm_pkg::REQ_REPORT, $urandom, 1'b0, 1'b0), 1'b0);
    drive_req(mk_row(ptslm_pkg::REQ_REPORT, $urandom, 1'b0, 1'b1), 1'b1);
    drive_req(mk_row(ptslm_pkg::REQ_REPORT, $urandom, 1'b0, 1'b0), 1'b1);

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### press_to_send_latency_monitor_unit.f
rtl/ptslm_pkg.sv
rtl/ptslm_div.sv
rtl/press_to_send_latency_monitor_unit.sv
bench/press_to_send_latency_monitor_unit_tb.sv
